>>> design/wsdf_pkg.sv
// Shared types and constants for the WebSocket text frame deframer.
`timescale 1ns / 1ps

package wsdf_pkg;

  localparam int unsigned MaxPayloadDef = 125;
  localparam int unsigned LenW          = 7;
  localparam int unsigned KeyDepth      = 4;

  localparam logic [7:0] FinBit     = 8'h80;
  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] OpcodeText = 8'h01;
  localparam logic [7:0] LenMask    = 8'h7F;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_KEY  = 3'd2,
    PH_DATA = 3'd3,
    PH_DROP = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA  = 3'd0,
    ST_EMPTY = 3'd1,
    ST_OPC   = 3'd2,
    ST_LEN   = 3'd3,
    ST_TRUNC = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_item;
    status_e    status;
  } res_t;

endpackage

>>> design/wsdf_in_stage.sv
// Input register stage of the deframer.
`timescale 1ns / 1ps

module wsdf_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wsdf_pkg::in_item_t item_i,
  input  logic               adv_i,
  output logic               vld_o,
  output wsdf_pkg::in_item_t item_o
);

  logic               vld_q;
  wsdf_pkg::in_item_t item_q;

  // Hold the registered byte while the result side cannot advance.
  assign in_stall_o = vld_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || adv_i) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

>>> design/wsdf_decode.sv
// Frame state machine: header checks, key capture and payload unmasking.
`timescale 1ns / 1ps

module wsdf_decode #(
  parameter int unsigned MAX_PAYLOAD = wsdf_pkg::MaxPayloadDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  wsdf_pkg::in_item_t item_i,
  output logic               emit_o,
  output wsdf_pkg::res_t     res_o
);

  localparam logic [wsdf_pkg::LenW-1:0] MaxLen = wsdf_pkg::LenW'(MAX_PAYLOAD);

  wsdf_pkg::phase_e            phase_q, phase_d;
  logic [wsdf_pkg::LenW-1:0]   bytes_left_q, bytes_left_d;
  logic [1:0]                  slot_q, slot_d;
  logic [7:0]                  key_q [wsdf_pkg::KeyDepth];
  logic                        key_we;

  logic [7:0]                  b;
  logic                        last;
  logic                        hdr_bad;
  logic [wsdf_pkg::LenW-1:0]   len;
  logic                        len_bad;
  logic [7:0]                  unmasked;

  assign b        = item_i.frame_byte;
  assign last     = item_i.buffer_end;
  assign hdr_bad  = ((b & wsdf_pkg::FinBit) != wsdf_pkg::FinBit) ||
                    ((b & wsdf_pkg::OpcodeMask) != wsdf_pkg::OpcodeText);
  assign len      = b[wsdf_pkg::LenW-1:0];
  assign len_bad  = len > MaxLen;
  assign unmasked = b ^ key_q[slot_q];

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    slot_d       = slot_q;
    key_we       = 1'b0;
    unique case (phase_q)
      wsdf_pkg::PH_HDR0: begin
        if (hdr_bad) phase_d = wsdf_pkg::PH_DROP;
        else if (!last) phase_d = wsdf_pkg::PH_HDR1;
      end
      wsdf_pkg::PH_HDR1: begin
        if (len_bad) begin
          phase_d = wsdf_pkg::PH_DROP;
        end else if (!last) begin
          bytes_left_d = len;
          slot_d       = 2'd0;
          phase_d      = wsdf_pkg::PH_KEY;
        end
      end
      wsdf_pkg::PH_KEY: begin
        key_we = 1'b1;
        if (slot_q == 2'd3) begin
          slot_d = 2'd0;
          if (bytes_left_q == '0) phase_d = wsdf_pkg::PH_DROP;
          else if (!last) phase_d = wsdf_pkg::PH_DATA;
        end else if (!last) begin
          slot_d = slot_q + 2'd1;
        end
      end
      wsdf_pkg::PH_DATA: begin
        if (bytes_left_q <= wsdf_pkg::LenW'(1)) begin
          bytes_left_d = '0;
          phase_d      = wsdf_pkg::PH_DROP;
        end else if (!last) begin
          bytes_left_d = bytes_left_q - wsdf_pkg::LenW'(1);
          slot_d       = slot_q + 2'd1;
        end
      end
      default: ;
    endcase
    // A buffer boundary always restarts at the first header byte.
    if (last) begin
      phase_d      = wsdf_pkg::PH_HDR0;
      bytes_left_d = '0;
      slot_d       = 2'd0;
    end
  end

  // Result for this byte.
  always_comb begin
    emit_o           = 1'b0;
    res_o.data_byte  = 8'h00;
    res_o.final_item = 1'b1;
    res_o.status     = wsdf_pkg::ST_DATA;
    unique case (phase_q)
      wsdf_pkg::PH_HDR0: begin
        priority if (hdr_bad) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_OPC;
        end else if (last) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_TRUNC;
        end else begin
          emit_o = 1'b0;
        end
      end
      wsdf_pkg::PH_HDR1: begin
        priority if (len_bad) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_LEN;
        end else if (last) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_TRUNC;
        end else begin
          emit_o = 1'b0;
        end
      end
      wsdf_pkg::PH_KEY: begin
        priority if (slot_q == 2'd3 && bytes_left_q == '0) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_EMPTY;
        end else if (last) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_TRUNC;
        end else begin
          emit_o = 1'b0;
        end
      end
      wsdf_pkg::PH_DATA: begin
        priority if (bytes_left_q <= wsdf_pkg::LenW'(1)) begin
          emit_o          = 1'b1;
          res_o.data_byte = unmasked;
        end else if (last) begin
          emit_o = 1'b1;  res_o.status = wsdf_pkg::ST_TRUNC;
        end else begin
          emit_o           = 1'b1;
          res_o.data_byte  = unmasked;
          res_o.final_item = 1'b0;
        end
      end
      default: emit_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wsdf_pkg::PH_HDR0;
      bytes_left_q <= '0;
      slot_q       <= 2'd0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      slot_q       <= slot_d;
    end
  end

  // Key bytes are always rewritten before use, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (fire_i && key_we) begin
      key_q[slot_q] <= b;
    end
  end

endmodule

>>> design/wsdf_res_stage.sv
// Result register stage of the deframer.
`timescale 1ns / 1ps

module wsdf_res_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  logic           emit_i,
  input  wsdf_pkg::res_t res_i,
  output logic           adv_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wsdf_pkg::res_t res_o
);

  logic           vld_q;
  wsdf_pkg::res_t res_q;

  // Advance whenever the result register is empty or being taken.
  assign adv_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= vld_i && emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

>>> design/websocket_text_frame_deframer_core.sv
// Top level of the WebSocket text frame deframer.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   input   | in        | in_valid_i/in_stall_o | frame_byte_i, buffer_end_i
//   result  | out       | out_valid_o/out_stall_i | data_byte_o, final_item_o, status_o
//
// One byte per cycle is taken unless the result side stalls; each byte is held in the
// input register, and its result, if any, then appears from the result register.
// The frame state machine updates once per byte.
// Reset clears the phase, length count, key slot and both valid flags.
// A stall on the result side holds both registers; the input stalls only when
// its register is full and cannot move on.
`timescale 1ns / 1ps

module websocket_text_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = wsdf_pkg::MaxPayloadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] frame_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       final_item_o,
  output logic [2:0] status_o
);

  wsdf_pkg::in_item_t in_item, stage_item;
  wsdf_pkg::res_t     dec_res, out_res;
  logic               stage_vld;
  logic               adv;
  logic               emit;

  assign in_item.frame_byte = frame_byte_i;
  assign in_item.buffer_end = buffer_end_i;

  wsdf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  wsdf_decode #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (stage_vld && adv),
    .item_i (stage_item),
    .emit_o (emit),
    .res_o  (dec_res)
  );

  wsdf_res_stage u_res_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (stage_vld),
    .emit_i      (emit),
    .res_i       (dec_res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign data_byte_o  = out_res.data_byte;
  assign final_item_o = out_res.final_item;
  assign status_o     = 3'(out_res.status);

endmodule
